// ===== hdl/xoopc_pkg.sv =====
package xoopc_pkg;

    localparam int LANE_W = 32;
    localparam int NUM_LANES = 4;
    localparam int NUM_PLANES = 3;
    localparam int NUM_RC = 12;
    localparam int MAX_ROUNDS_DEF = 12;
    localparam int ROUNDS_W = 4;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd12;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [NUM_LANES-1:0] plane_t;
    typedef plane_t [NUM_PLANES-1:0] state_t;
    typedef lane_t [NUM_LANES-1:0] parity_t;

    // What moves from one round cell to the next.
    typedef struct packed {
        logic    valid;
        logic    fault;
        state_t  state;
        parity_t par;
    } stage_t;

    localparam lane_t ROUND_CONSTS [NUM_RC] = '{
        32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
        32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
        32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
    };

    // Rotation by a constant amount in 1..31.
    function automatic lane_t rotl(input lane_t v, input int r);
        rotl = (v << r) | (v >> (LANE_W - r));
    endfunction

    // High when any lane's column parity differs from the prediction.
    function automatic logic parity_bad(input state_t a, input parity_t p);
        logic bad;
        bad = 1'b0;
        for (int x = 0; x < NUM_LANES; x++) begin
            if ((a[0][2'(x)] ^ a[1][2'(x)] ^ a[2][2'(x)]) != p[2'(x)]) begin
                bad = 1'b1;
            end
        end
        parity_bad = bad;
    endfunction

endpackage

// ===== hdl/xoopc_round_cell.sv =====
module xoopc_round_cell
    import xoopc_pkg::*;
#(
    parameter lane_t RC = 32'h0000_0012
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   active,
    input  stage_t stage_in,
    output stage_t stage_out
);

    state_t  a;
    state_t  old;
    parity_t par;
    parity_t e;
    lane_t   t0;
    lane_t   t1;
    lane_t   t2;
    logic    bad;

    logic    valid_reg;
    logic    fault_reg;
    logic    fault_next;
    state_t  state_reg;
    state_t  state_next;
    parity_t par_reg;
    parity_t par_next;

    always_comb
    begin
        a = stage_in.state;
        par = stage_in.par;
        bad = 1'b0;
        e = '0;
        t0 = '0;
        t1 = '0;
        t2 = '0;

        // theta: the column parity feeds the effect on every plane.
        for (int x = 0; x < NUM_LANES; x++) begin
            e[2'(x)] = rotl(par[2'(x + 3)], 5) ^ rotl(par[2'(x + 3)], 14);
        end
        for (int x = 0; x < NUM_LANES; x++) begin
            for (int y = 0; y < NUM_PLANES; y++) begin
                a[2'(y)][2'(x)] = a[2'(y)][2'(x)] ^ e[2'(x)];
            end
            par[2'(x)] = par[2'(x)] ^ e[2'(x)];
        end
        bad = bad | parity_bad(a, par);

        // Westward shift: plane 1 moves by one lane, plane 2 rotates by 11.
        old = a;
        for (int x = 0; x < NUM_LANES; x++) begin
            a[1][2'(x)] = old[1][2'(x + 3)];
            a[2][2'(x)] = rotl(old[2][2'(x)], 11);
            par[2'(x)] = old[0][2'(x)] ^ old[1][2'(x + 3)] ^ rotl(old[2][2'(x)], 11);
        end
        bad = bad | parity_bad(a, par);

        // iota
        a[0][0] = a[0][0] ^ RC;
        par[0] = par[0] ^ RC;
        bad = bad | parity_bad(a, par);

        // chi works on the plane values from before the step.
        old = a;
        for (int x = 0; x < NUM_LANES; x++) begin
            t0 = ~old[1][2'(x)] & old[2][2'(x)];
            t1 = ~old[2][2'(x)] & old[0][2'(x)];
            t2 = ~old[0][2'(x)] & old[1][2'(x)];
            a[0][2'(x)] = old[0][2'(x)] ^ t0;
            a[1][2'(x)] = old[1][2'(x)] ^ t1;
            a[2][2'(x)] = old[2][2'(x)] ^ t2;
            par[2'(x)] = par[2'(x)] ^ t0 ^ t1 ^ t2;
        end
        bad = bad | parity_bad(a, par);

        // Eastward shift: plane 1 rotates by 1, plane 2 moves by two lanes
        // and rotates by 8.
        old = a;
        for (int x = 0; x < NUM_LANES; x++) begin
            a[1][2'(x)] = rotl(old[1][2'(x)], 1);
            a[2][2'(x)] = rotl(old[2][2'(x + 2)], 8);
            par[2'(x)] = old[0][2'(x)] ^ a[1][2'(x)] ^ a[2][2'(x)];
        end
        bad = bad | parity_bad(a, par);
    end

    // A cell whose round is not selected hands its input on unchanged.
    always_comb
    begin
        if (active) begin
            state_next = a;
            par_next = par;
            fault_next = stage_in.fault | bad;
        end else begin
            state_next = stage_in.state;
            par_next = stage_in.par;
            fault_next = stage_in.fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        par_reg <= par_next;
        fault_reg <= fault_next;
    end

    assign stage_out = '{
        valid: valid_reg,
        fault: fault_reg,
        state: state_reg,
        par:   par_reg
    };

endmodule

// ===== hdl/xoodoo_permutation_parity_checked_unit.sv =====
// Applies the last num_rounds rounds of the 384-bit Xoodoo permutation and
// checks a predicted column parity after every step; fault_detected reports
// any mismatch. The unit takes a new state in every clock cycle (busy stays
// low) and raises done once the state has passed the chain of round cells,
// one registered cell per round; cells for rounds that num_rounds leaves out
// pass the state along unchanged. The receiver cannot stall the unit: each
// result stands on the outputs for the single cycle that done is high and
// must be taken then. The user writes num_rounds through cfg_we and cfg_wdata
// only while no transfer is in flight; the unit does not enforce this.
// Values above MAX_ROUNDS act as MAX_ROUNDS.
module xoodoo_permutation_parity_checked_unit
    import xoopc_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [ROUNDS_W-1:0] cfg_wdata,
    input  logic [63:0]         in_plane0_lanes01,
    input  logic [63:0]         in_plane0_lanes23,
    input  logic [63:0]         in_plane1_lanes01,
    input  logic [63:0]         in_plane1_lanes23,
    input  logic [63:0]         in_plane2_lanes01,
    input  logic [63:0]         in_plane2_lanes23,
    output logic                done,
    output logic [63:0]         out_plane0_lanes01,
    output logic [63:0]         out_plane0_lanes23,
    output logic [63:0]         out_plane1_lanes01,
    output logic [63:0]         out_plane1_lanes23,
    output logic [63:0]         out_plane2_lanes01,
    output logic [63:0]         out_plane2_lanes23,
    output logic                fault_detected
);

    localparam logic [ROUNDS_W-1:0] MAX_N = ROUNDS_W'(MAX_ROUNDS);

    logic [ROUNDS_W-1:0] num_rounds_reg;
    logic [ROUNDS_W-1:0] rounds_eff;
    state_t              in_state;
    parity_t             in_par;
    stage_t              chain [MAX_ROUNDS+1];
    state_t              res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            num_rounds_reg <= ROUNDS_RESET;
        end else if (cfg_we) begin
            num_rounds_reg <= cfg_wdata;
        end
    end

    assign rounds_eff = (num_rounds_reg > MAX_N) ? MAX_N : num_rounds_reg;

    always_comb
    begin
        in_state[0] = {in_plane0_lanes23, in_plane0_lanes01};
        in_state[1] = {in_plane1_lanes23, in_plane1_lanes01};
        in_state[2] = {in_plane2_lanes23, in_plane2_lanes01};
        for (int x = 0; x < NUM_LANES; x++) begin
            in_par[2'(x)] = in_state[0][2'(x)] ^ in_state[1][2'(x)] ^ in_state[2][2'(x)];
        end
    end

    assign chain[0] = '{valid: start, fault: 1'b0, state: in_state, par: in_par};

    // Cell k carries round constant 12 - MAX_ROUNDS + k and is active when
    // it is among the last rounds_eff cells.
    for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_cell
        localparam int RC_IDX = NUM_RC - MAX_ROUNDS + k;
        logic active;

        assign active = ({1'b0, rounds_eff} + (ROUNDS_W + 1)'(k))
                        >= (ROUNDS_W + 1)'(MAX_ROUNDS);

        xoopc_round_cell #(
            .RC(ROUND_CONSTS[RC_IDX])
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (active),
            .stage_in (chain[k]),
            .stage_out(chain[k+1])
        );
    end

    assign res = chain[MAX_ROUNDS].state;

    assign busy = 1'b0;
    assign done = chain[MAX_ROUNDS].valid;
    assign fault_detected = chain[MAX_ROUNDS].fault;
    assign out_plane0_lanes01 = res[0][1:0];
    assign out_plane0_lanes23 = res[0][3:2];
    assign out_plane1_lanes01 = res[1][1:0];
    assign out_plane1_lanes23 = res[1][3:2];
    assign out_plane2_lanes01 = res[2][1:0];
    assign out_plane2_lanes23 = res[2][3:2];

endmodule
